### rtl/fsde_pkg.sv
// Package for the framebuffer shape drawing engine.
// Holds opcodes, sequencer state encoding and the shared payload types.
`default_nettype none
package fsde_pkg;

    localparam int unsigned OP_W    = 4;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned RAD_W   = 7;
    localparam int unsigned PIX_W   = 8;

    localparam logic [PIX_W-1:0] BLANK_CODE = 8'd32;

    localparam logic [OP_W-1:0] OP_PIXEL   = 4'd0;
    localparam logic [OP_W-1:0] OP_HLINE   = 4'd1;
    localparam logic [OP_W-1:0] OP_VLINE   = 4'd2;
    localparam logic [OP_W-1:0] OP_FRECT   = 4'd3;
    localparam logic [OP_W-1:0] OP_ORECT   = 4'd4;
    localparam logic [OP_W-1:0] OP_TRECT   = 4'd5;
    localparam logic [OP_W-1:0] OP_FCIRC   = 4'd6;
    localparam logic [OP_W-1:0] OP_OCIRC   = 4'd7;
    localparam logic [OP_W-1:0] OP_TCIRC   = 4'd8;
    localparam logic [OP_W-1:0] OP_READ    = 4'd9;
    localparam logic [OP_W-1:0] OP_CLEAR   = 4'd10;

    typedef enum logic [3:0] {
        S_CLEAR,     // sweep memory with blank code
        S_IDLE,
        S_RECT_NEXT, // load next rectangle of the current command
        S_RECT,      // walk rectangle pixels
        S_CIRC_ROW,  // start a circle row
        S_CIRC_SHR,  // shrink half width
        S_CIRC_EMIT, // emit row spans or outline points
        S_READ,      // wait for read data
        S_OUT        // hold result
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [COORD_W-1:0] x_pos;
        logic signed [COORD_W-1:0] y_pos;
        logic [LEN_W-1:0]         width;
        logic [LEN_W-1:0]         height;
        logic [RAD_W-1:0]         radius;
        logic [RAD_W-1:0]         thickness;
        logic [PIX_W-1:0]         color;
    } t_cmd;

    typedef struct packed {
        logic [PIX_W-1:0] read_data;
        logic [OP_W-1:0]  done_op;
    } t_res;

endpackage
`default_nettype wire

### rtl/fsde_stream_if.sv
// Valid/ready channel interface for commands and results.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface fsde_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/framebuffer_shape_drawing_engine.sv
// Raster shape engine over a SCREEN_W x SCREEN_H framebuffer in one synchronous RAM.
// Each pixel walked is its own step, with a further step per rectangle and, for circles,
// per ring and per half-width step of each row. One command at a time; the output
// register lets the next command start while the last result waits; the RAM write
// port sets the pace. Reset (synchronous, active low) and the clear command sweep all
// SCREEN_W*SCREEN_H entries to blank, one per cycle, with no command accepted meanwhile.
`default_nettype none
module framebuffer_shape_drawing_engine #(
    parameter int SCREEN_W = 128,
    parameter int SCREEN_H = 96
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fsde_stream_if.sink   i_cmd,
    fsde_stream_if.source o_res
);
    import fsde_pkg::*;

    localparam int DEPTH  = SCREEN_W * SCREEN_H;
    localparam int AW     = $clog2(DEPTH);
    localparam int XW     = $clog2(SCREEN_W);
    localparam int YW     = $clog2(SCREEN_H);
    // signed working width for all coordinate arithmetic
    localparam int CW     = 16;
    localparam logic signed [CW-1:0] ONE  = CW'(1);
    localparam logic signed [CW-1:0] ZERO = '0;

    // framebuffer storage
    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    t_res   r_res, n_res;
    // output register: holds a finished result until the sink takes it
    t_res   r_out, n_out;
    logic   r_ovld, n_ovld;

    logic [AW-1:0] r_clr, n_clr;

    // rectangle walker: origin, size and cursor
    logic signed [CW-1:0] r_rx, n_rx, r_ry, n_ry;
    logic signed [CW-1:0] r_rw, n_rw, r_rh, n_rh;
    logic signed [CW-1:0] r_ci, n_ci, r_cj, n_cj;
    logic [2:0] r_part, n_part;

    // circle walker
    logic signed [CW-1:0] r_cr, n_cr;  // current ring radius
    logic signed [CW-1:0] r_d, n_d;
    logic signed [CW-1:0] r_k, n_k;
    logic [2:0] r_pt, n_pt;            // point or span index within a row
    logic [RAD_W-1:0] r_rings, n_rings;
    logic [CW-1:0] r_ssum, n_ssum;     // d*d + k*k
    logic [CW-1:0] r_rsq, n_rsq;       // r*r

    // write port request
    logic                 we;
    logic signed [CW-1:0] wx, wy;
    logic [AW-1:0]        waddr;
    logic [PIX_W-1:0]     wdata;
    logic                 w_on;
    logic [AW-1:0]        raddr;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_res   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_res   <= n_res;
            r_ovld  <= n_ovld;
        end
        r_cmd <= n_cmd; r_out <= n_out;
        r_rx <= n_rx; r_ry <= n_ry; r_rw <= n_rw; r_rh <= n_rh;
        r_ci <= n_ci; r_cj <= n_cj; r_part <= n_part;
        r_cr <= n_cr; r_d <= n_d; r_k <= n_k; r_pt <= n_pt;
        r_rings <= n_rings; r_ssum <= n_ssum; r_rsq <= n_rsq;
    end

    logic signed [CW-1:0] cx, cy, cw, ch, ct, cr;
    logic signed [CW-1:0] px, py;

    always_comb begin
        cx = CW'(r_cmd.x_pos);
        cy = CW'(r_cmd.y_pos);
        cw = CW'({1'b0, r_cmd.width});
        ch = CW'({1'b0, r_cmd.height});
        ct = CW'({1'b0, r_cmd.thickness});
        cr = CW'({1'b0, r_cmd.radius});
        // pixel on screen: the write is enabled only when inside
        w_on  = (wx >= ZERO) && (wy >= ZERO) && (wx < CW'(SCREEN_W))
                && (wy < CW'(SCREEN_H));
        // the clear sweep walks the RAM linearly
        waddr = (r_state == S_CLEAR) ? r_clr
                                     : AW'(wy[YW:0] * SCREEN_W + wx[XW:0]);
    end

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_res = r_res; n_clr = r_clr;
        n_out = r_out; n_ovld = r_ovld;
        n_rx = r_rx; n_ry = r_ry; n_rw = r_rw; n_rh = r_rh;
        n_ci = r_ci; n_cj = r_cj; n_part = r_part;
        n_cr = r_cr; n_d = r_d; n_k = r_k; n_pt = r_pt;
        n_rings = r_rings; n_ssum = r_ssum; n_rsq = r_rsq;
        we = 1'b0; wx = '0; wy = '0; wdata = r_cmd.color;
        raddr = waddr;
        px = '0; py = '0;
        i_cmd.ready = 1'b0;
        o_res.valid = r_ovld;
        o_res.data  = r_out;
        // drop the held result once the sink takes it
        if (o_res.ready) n_ovld = 1'b0;

        case (r_state)
            S_CLEAR: begin
                // sweep the whole RAM with blank, then report only for a clear command
                we = 1'b1;
                wdata = BLANK_CODE;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_clr = '0;
                    n_state = (r_cmd.op == OP_CLEAR && r_res.done_op == OP_CLEAR)
                              ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_cmd = i_cmd.data;
                    n_res = '{read_data: '0, done_op: i_cmd.data.op};
                    n_part = '0;
                    n_rings = '0;
                    case (i_cmd.data.op)
                        OP_PIXEL, OP_HLINE, OP_VLINE, OP_FRECT,
                        OP_ORECT, OP_TRECT: n_state = S_RECT_NEXT;
                        OP_FCIRC, OP_OCIRC, OP_TCIRC: begin
                            n_cr = CW'({1'b0, i_cmd.data.radius});
                            n_state = S_CIRC_ROW;
                        end
                        OP_READ:  n_state = S_READ;
                        OP_CLEAR: n_state = S_CLEAR;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_RECT_NEXT: begin
                // pick rectangle number r_part of the command
                n_ci = '0; n_cj = '0;
                n_part = r_part + 3'd1;
                n_state = S_RECT;
                n_rx = cx; n_ry = cy; n_rw = cw; n_rh = ch;
                case (r_cmd.op)
                    OP_PIXEL: begin n_rw = ONE; n_rh = ONE; end
                    OP_HLINE: n_rh = ONE;
                    OP_VLINE: n_rw = ONE;
                    OP_FRECT: ;
                    OP_ORECT: begin
                        case (r_part)
                            3'd0: n_rh = ONE;
                            3'd1: n_rw = ONE;
                            3'd2: begin n_ry = cy + ch - ONE; n_rh = ONE; end
                            default: begin n_rx = cx + cw - ONE; n_rw = ONE; end
                        endcase
                    end
                    OP_TRECT: begin
                        case (r_part)
                            3'd0: n_rh = ct;
                            3'd1: begin n_ry = cy + ch - ct; n_rh = ct; end
                            3'd2: n_rw = ct;
                            default: begin n_rx = cx + cw - ct; n_rw = ct; end
                        endcase
                    end
                    default: ;
                endcase
                if (n_rw <= ZERO || n_rh <= ZERO) begin
                    n_state = S_RECT_NEXT;
                    if (r_part == 3'd3 || r_cmd.op == OP_PIXEL || r_cmd.op == OP_HLINE
                        || r_cmd.op == OP_VLINE || r_cmd.op == OP_FRECT) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_RECT: begin
                wx = r_rx + r_ci;
                wy = r_ry + r_cj;
                we = w_on;
                n_ci = r_ci + ONE;
                if (r_ci == r_rw - ONE) begin
                    n_ci = '0;
                    n_cj = r_cj + ONE;
                    if (r_cj == r_rh - ONE) begin
                        n_state = (r_part == 3'd4 || r_cmd.op == OP_PIXEL
                                   || r_cmd.op == OP_HLINE || r_cmd.op == OP_VLINE
                                   || r_cmd.op == OP_FRECT) ? S_OUT : S_RECT_NEXT;
                    end
                end
            end
            S_CIRC_ROW: begin
                // new ring: k = 0, d = r
                n_k = '0;
                n_d = r_cr;
                n_rsq = CW'(r_cr[RAD_W-1:0] * r_cr[RAD_W-1:0]);
                n_ssum = CW'(r_cr[RAD_W-1:0] * r_cr[RAD_W-1:0]);
                if (r_cr <= ZERO || (r_cmd.op == OP_TCIRC
                    && (r_rings == r_cmd.thickness || r_rings == r_cmd.radius))) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_CIRC_SHR;
                end
            end
            S_CIRC_SHR: begin
                // d*d + k*k held in r_ssum; step d down one per cycle
                if (r_ssum > r_rsq) begin
                    n_d = r_d - ONE;
                    n_ssum = r_ssum - CW'({r_d[RAD_W-1:0], 1'b0}) + CW'(1);
                end else begin
                    n_pt = '0; n_ci = '0;
                    n_state = S_CIRC_EMIT;
                end
            end
            S_CIRC_EMIT: begin
                if (r_cmd.op == OP_FCIRC) begin
                    // two spans of length 2d from x-d
                    wx = cx - r_d + r_ci;
                    wy = r_pt[0] ? cy - r_k : cy + r_k;
                    we = w_on && (r_d > ZERO);
                    n_ci = r_ci + ONE;
                    if (r_d <= ZERO || r_ci == r_d + r_d - ONE) begin
                        n_ci = '0;
                        n_pt = r_pt + 3'd1;
                    end
                end else begin
                    case (r_pt)
                        3'd0: begin px = -r_d; py = -r_k; end
                        3'd1: begin px =  r_d; py = -r_k; end
                        3'd2: begin px = -r_d; py =  r_k; end
                        3'd3: begin px =  r_d; py =  r_k; end
                        3'd4: begin px = -r_k; py = -r_d; end
                        3'd5: begin px = -r_k; py =  r_d; end
                        3'd6: begin px =  r_k; py = -r_d; end
                        default: begin px = r_k; py = r_d; end
                    endcase
                    wx = cx + px; wy = cy + py;
                    we = w_on;
                    n_pt = r_pt + 3'd1;
                end
                if ((r_cmd.op == OP_FCIRC && n_pt == 3'd2 && r_pt == 3'd1)
                    || (r_cmd.op != OP_FCIRC && r_pt == 3'd7)) begin
                    n_k = r_k + ONE;
                    // k*k grows by 2k+1
                    n_ssum = r_ssum + CW'({r_k[RAD_W-1:0], 1'b0}) + CW'(1);
                    n_state = S_CIRC_SHR;
                    if (r_k == r_cr - ONE) begin
                        n_rings = r_rings + RAD_W'(1);
                        n_cr = r_cr - ONE;
                        n_state = (r_cmd.op == OP_TCIRC) ? S_CIRC_ROW : S_OUT;
                    end
                end
            end
            S_READ: begin
                // address presented this cycle, data lands next
                wx = cx; wy = cy;
                raddr = waddr;
                n_pt = r_pt + 3'd1;
                if (r_pt == 3'd1) begin
                    n_res.read_data = w_on ? r_rdata : '0;
                    n_pt = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // advance the result into the output register once it is free
                if (!r_ovld || o_res.ready) begin
                    n_out = r_res;
                    n_ovld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE) n_pt = '0;
    end

endmodule
`default_nettype wire
